// ===== hw/rtl/bbsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Bip buffer space manager package
// Shared widths, command codes and the state and result structures.
// ----------------------------------------------------------------------------
package bbsm_pkg;

    localparam int OFF_W            = 17;
    localparam int SPAN_OFF_W       = 16;
    localparam int CMD_W            = 3;
    localparam int MAX_BUFFER_BYTES = 65536;
    localparam int MIN_BUFFER_BYTES = 2;

    typedef logic [OFF_W-1:0] t_off;

    typedef enum logic [CMD_W-1:0] {
        CMD_REQ_READ     = 3'd0,
        CMD_COMMIT_READ  = 3'd1,
        CMD_REQ_WRITE    = 3'd2,
        CMD_COMMIT_WRITE = 3'd3,
        CMD_RESET        = 3'd4
    } t_cmd;

    typedef struct packed {
        t_off rd;
        t_off wr;
        t_off wm;
    } t_state;

    typedef struct packed {
        logic                  has_span;
        logic [SPAN_OFF_W-1:0] span_offset;
        t_off                  span_length;
    } t_result;

    localparam t_off MAX_SIZE = t_off'(MAX_BUFFER_BYTES);
    localparam t_off MIN_SIZE = t_off'(MIN_BUFFER_BYTES);

endpackage

// ===== hw/rtl/bbsm_calc.sv =====
// ----------------------------------------------------------------------------
// Bip buffer command evaluation
// Computes the next offsets and the result of one command from the current
// offsets, the registered command and the effective buffer size.
// ----------------------------------------------------------------------------
module bbsm_calc (
    input  bbsm_pkg::t_state         i_state,
    input  logic [bbsm_pkg::CMD_W-1:0] i_cmd,
    input  bbsm_pkg::t_off           i_cnt,
    input  bbsm_pkg::t_off           i_size,
    output bbsm_pkg::t_state         o_state,
    output bbsm_pkg::t_result        o_result
);

    function automatic bbsm_pkg::t_off sat_add(bbsm_pkg::t_off a, bbsm_pkg::t_off b,
                                               bbsm_pkg::t_off lim);
        logic [bbsm_pkg::OFF_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, lim}) ? lim : s[bbsm_pkg::OFF_W-1:0];
    endfunction

    function automatic bbsm_pkg::t_off sub0(bbsm_pkg::t_off a, bbsm_pkg::t_off b);
        return (a > b) ? (a - b) : '0;
    endfunction

    bbsm_pkg::t_off rd_wrapped;
    bbsm_pkg::t_off tail;
    bbsm_pkg::t_off gap;
    bbsm_pkg::t_off wr_sum;
    bbsm_pkg::t_off span_start;

    assign rd_wrapped = (i_state.wr != i_state.wm && i_state.rd == i_state.wm) ? '0
                                                                                : i_state.rd;
    assign tail   = sub0(i_size, i_state.wr);
    assign gap    = i_state.rd - i_state.wr;
    assign wr_sum = sat_add(i_state.wr, i_cnt, i_size);

    always_comb begin
        o_state    = i_state;
        o_result   = '0;
        span_start = '0;
        case (bbsm_pkg::t_cmd'(i_cmd))
            bbsm_pkg::CMD_REQ_READ: begin
                o_state.rd = rd_wrapped;
                span_start = rd_wrapped;
                if (rd_wrapped < i_state.wr) begin
                    o_result.has_span    = 1'b1;
                    o_result.span_length = i_state.wr - rd_wrapped;
                end else if (rd_wrapped > i_state.wr) begin
                    o_result.has_span    = 1'b1;
                    o_result.span_length = sub0(i_state.wm, rd_wrapped);
                end
            end
            bbsm_pkg::CMD_COMMIT_READ: begin
                o_state.rd = sat_add(i_state.rd, i_cnt, i_size);
            end
            bbsm_pkg::CMD_REQ_WRITE: begin
                if (i_state.rd <= i_state.wr) begin
                    o_state.wm = i_state.wr;
                    if (tail >= i_cnt) begin
                        o_result.has_span    = 1'b1;
                        o_result.span_length = tail;
                        span_start           = i_state.wr;
                    end else if (i_state.rd > i_cnt) begin
                        // The tail is too short, so wrap to the head region.
                        o_state.wr           = '0;
                        o_result.has_span    = 1'b1;
                        o_result.span_length = i_state.rd - 1'b1;
                    end
                end else if (gap > i_cnt) begin
                    o_result.has_span    = 1'b1;
                    o_result.span_length = gap - 1'b1;
                    span_start           = i_state.wr;
                end
            end
            bbsm_pkg::CMD_COMMIT_WRITE: begin
                o_state.wr = wr_sum;
                if (i_state.rd <= i_state.wr) begin
                    o_state.wm = wr_sum;
                end
            end
            bbsm_pkg::CMD_RESET: begin
                o_state.rd = '0;
                o_state.wr = '0;
                o_state.wm = i_size;
            end
            default: begin
            end
        endcase
        if (o_result.has_span) begin
            o_result.span_offset = span_start[bbsm_pkg::SPAN_OFF_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/bip_buffer_space_manager_core.sv =====
// ----------------------------------------------------------------------------
// Bip buffer space manager
// Tracks the read, write and watermark offsets of a bipartite circular buffer
// and answers read and write span requests. Every command beat gives exactly
// one result beat. A command is registered on entry; from the command register
// it is evaluated once the result register can advance, and then the offsets
// are updated and the result is registered. One command is taken every cycle
// while the result side is not stalled. The buffer size is clamped to 2..65536
// when written and should be changed only while idle.
// ----------------------------------------------------------------------------
module bip_buffer_space_manager_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bbsm_pkg::OFF_W-1:0]      i_cfg_data,
    // command channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bbsm_pkg::CMD_W-1:0]      i_command,
    input  logic [bbsm_pkg::OFF_W-1:0]      i_byte_count,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_has_span,
    output logic [bbsm_pkg::SPAN_OFF_W-1:0] o_span_offset,
    output logic [bbsm_pkg::OFF_W-1:0]      o_span_length
);

    bbsm_pkg::t_off               r_size;
    bbsm_pkg::t_off               n_size;
    bbsm_pkg::t_state             r_st;
    bbsm_pkg::t_state             n_st;
    logic                         r_s1_vld;
    logic [bbsm_pkg::CMD_W-1:0]   r_cmd;
    bbsm_pkg::t_off               r_cnt;
    logic                         r_out_vld;
    bbsm_pkg::t_result            r_res;
    bbsm_pkg::t_result            n_res;
    logic                         out_adv;
    logic                         s1_go;
    logic                         in_acc;

    assign out_adv    = !r_out_vld || !i_out_stall;
    assign s1_go      = r_s1_vld && out_adv;
    assign o_in_stall = r_s1_vld && !out_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data > bbsm_pkg::MAX_SIZE) begin
            n_size = bbsm_pkg::MAX_SIZE;
        end else if (i_cfg_data < bbsm_pkg::MIN_SIZE) begin
            n_size = bbsm_pkg::MIN_SIZE;
        end else begin
            n_size = i_cfg_data;
        end
    end

    // Size register: holds the clamped size so the datapath never clamps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= bbsm_pkg::MAX_SIZE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_size <= n_size;
        end
    end

    bbsm_calc u_calc (
        .i_state  (r_st),
        .i_cmd    (r_cmd),
        .i_cnt    (r_cnt),
        .i_size   (r_size),
        .o_state  (n_st),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= '0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_out_vld <= 1'b1;
                r_st      <= n_st;
            end else if (out_adv) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_command;
            r_cnt <= i_byte_count;
        end
        if (s1_go) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_has_span    = r_res.has_span;
    assign o_span_offset = r_res.span_offset;
    assign o_span_length = r_res.span_length;

    // A result without a span carries all-zero fields.
    a_no_span_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_span |-> o_span_offset == '0 && o_span_length == '0)
        else $error("result without span has nonzero fields");

    // A reset command empties the buffer.
    a_reset_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_cmd == bbsm_pkg::CMD_RESET |=> r_st.rd == '0 && r_st.wr == '0)
        else $error("reset command left offsets nonzero");

    // A read commit never moves the read offset past the buffer size.
    a_commit_read_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_cmd == bbsm_pkg::CMD_COMMIT_READ |=> r_st.rd <= $past(r_size))
        else $error("read offset beyond buffer size after commit");

    // A full command stage with a blocked result register must stall input.
    a_stall_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_out_vld && i_out_stall |-> o_in_stall)
        else $error("command stage overrun");

endmodule

// ===== dv/bip_buffer_space_manager_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bip buffer space manager testbench
// Drives read and write requests and commits, resets and spare codes under several
// buffer sizes, with random gaps on the command side and random stalls on the result
// side. Each result beat is compared with a directed row's span or a bench predictor.
// ----------------------------------------------------------------------------
module bip_buffer_space_manager_core_tb;

    localparam logic [bbsm_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [bbsm_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [bbsm_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam logic              TYPED       = 1'b1;
    localparam logic              PRED        = 1'b0;
    localparam bbsm_pkg::t_result NO_SPAN     = '0;
    localparam int                N_DIR       = 25;
    localparam int                N_PHASE     = 10;
    localparam int                PHASE_ITEMS = 125;
    localparam int                QUIET_PHASE = 6;

    typedef struct packed {
        logic [bbsm_pkg::CMD_W-1:0] cmd;
        bbsm_pkg::t_off             cnt;
        logic                       typed;
        bbsm_pkg::t_result          want;
    } t_step;

    logic                            i_clk        = 1'b0;
    logic                            i_rst_n      = 1'b0;
    logic                            i_cfg_valid  = 1'b0;
    logic [bbsm_pkg::OFF_W-1:0]      i_cfg_data   = '0;
    logic                            i_in_valid   = 1'b0;
    logic [bbsm_pkg::CMD_W-1:0]      i_command    = '0;
    logic [bbsm_pkg::OFF_W-1:0]      i_byte_count = '0;
    logic                            i_out_stall  = 1'b0;
    logic                            o_cfg_ready;
    logic                            o_in_stall;
    logic                            o_out_valid;
    logic                            o_has_span;
    logic [bbsm_pkg::SPAN_OFF_W-1:0] o_span_offset;
    logic [bbsm_pkg::OFF_W-1:0]      o_span_length;

    // Predictor state: the three offsets and the raw size register.
    bbsm_pkg::t_off    rd_off   = '0;
    bbsm_pkg::t_off    wr_off   = '0;
    bbsm_pkg::t_off    wm_off   = '0;
    bbsm_pkg::t_off    cfg_size = bbsm_pkg::MAX_SIZE;
    bbsm_pkg::t_result span_q[$];
    int                n_fail   = 0;
    bit                gaps_on  = 1'b1;

    bbsm_pkg::t_off phase_sizes [N_PHASE] = '{17'd0, 17'd16, 17'd1, 17'd200, 17'd131071,
                                              17'd2, 17'd65535, 17'd37, 17'd65537, 17'd9};

    // Directed rows start from the reset size of 65536 bytes.
    t_step dir_steps [N_DIR] = '{
        '{bbsm_pkg::CMD_REQ_READ,     17'd0,      TYPED, NO_SPAN},
        '{bbsm_pkg::CMD_REQ_WRITE,    17'd0,      TYPED, '{1'b1, 16'd0, 17'd65536}},
        '{bbsm_pkg::CMD_REQ_WRITE,    17'd65536,  TYPED, '{1'b1, 16'd0, 17'd65536}},
        '{bbsm_pkg::CMD_REQ_WRITE,    17'd131071, TYPED, NO_SPAN},
        '{bbsm_pkg::CMD_COMMIT_WRITE, 17'd100,    TYPED, NO_SPAN},
        '{bbsm_pkg::CMD_REQ_READ,     17'd0,      TYPED, '{1'b1, 16'd0, 17'd100}},
        '{bbsm_pkg::CMD_COMMIT_READ,  17'd40,     TYPED, NO_SPAN},
        '{bbsm_pkg::CMD_REQ_WRITE,    17'd65436,  PRED,  NO_SPAN},
        '{bbsm_pkg::CMD_REQ_WRITE,    17'd65437,  PRED,  NO_SPAN},
        '{bbsm_pkg::CMD_COMMIT_WRITE, 17'd131071, TYPED, NO_SPAN},
        '{bbsm_pkg::CMD_REQ_WRITE,    17'd0,      PRED,  NO_SPAN},
        '{bbsm_pkg::CMD_REQ_WRITE,    17'd10,     PRED,  NO_SPAN},
        '{bbsm_pkg::CMD_REQ_READ,     17'd0,      PRED,  NO_SPAN},
        '{bbsm_pkg::CMD_COMMIT_WRITE, 17'd20,     PRED,  NO_SPAN},
        '{bbsm_pkg::CMD_REQ_WRITE,    17'd19,     PRED,  NO_SPAN},
        '{bbsm_pkg::CMD_REQ_WRITE,    17'd20,     PRED,  NO_SPAN},
        '{bbsm_pkg::CMD_COMMIT_READ,  17'd65496,  PRED,  NO_SPAN},
        '{bbsm_pkg::CMD_REQ_READ,     17'd0,      PRED,  NO_SPAN},
        '{bbsm_pkg::CMD_RESET,        17'd131071, TYPED, NO_SPAN},
        '{bbsm_pkg::CMD_COMMIT_WRITE, 17'd10,     TYPED, NO_SPAN},
        '{bbsm_pkg::CMD_COMMIT_READ,  17'd131071, TYPED, NO_SPAN},
        '{bbsm_pkg::CMD_REQ_READ,     17'd0,      PRED,  NO_SPAN},
        '{CMD_SPARE_5,                17'd131071, TYPED, NO_SPAN},
        '{CMD_SPARE_6,                17'd0,      TYPED, NO_SPAN},
        '{CMD_SPARE_7,                17'd65536,  TYPED, NO_SPAN}
    };

    bip_buffer_space_manager_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_byte_count  (i_byte_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_has_span    (o_has_span),
        .o_span_offset (o_span_offset),
        .o_span_length (o_span_length)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned eff_bytes(input bbsm_pkg::t_off raw);
        int unsigned s;
        s = {15'd0, raw};
        if (s > bbsm_pkg::MAX_BUFFER_BYTES) s = bbsm_pkg::MAX_BUFFER_BYTES;
        if (s < bbsm_pkg::MIN_BUFFER_BYTES) s = bbsm_pkg::MIN_BUFFER_BYTES;
        return s;
    endfunction

    function automatic bbsm_pkg::t_off sat_to(input bbsm_pkg::t_off a,
                                              input bbsm_pkg::t_off b,
                                              input int unsigned lim);
        int unsigned s;
        s = {15'd0, a} + {15'd0, b};
        return bbsm_pkg::t_off'((s > lim) ? lim : s);
    endfunction

    // Applies one command to the offsets and gives the span it returns.
    function automatic bbsm_pkg::t_result span_predict(input logic [bbsm_pkg::CMD_W-1:0] cmd,
                                                       input bbsm_pkg::t_off cnt);
        int unsigned       sz;
        int unsigned       tail;
        bbsm_pkg::t_result r;
        sz = eff_bytes(cfg_size);
        r  = NO_SPAN;
        case (cmd)
            bbsm_pkg::CMD_REQ_READ: begin
                if (wr_off != wm_off && rd_off == wm_off) rd_off = '0;
                if (rd_off < wr_off) begin
                    r.has_span    = 1'b1;
                    r.span_offset = rd_off[bbsm_pkg::SPAN_OFF_W-1:0];
                    r.span_length = wr_off - rd_off;
                end else if (rd_off > wr_off) begin
                    r.has_span    = 1'b1;
                    r.span_offset = rd_off[bbsm_pkg::SPAN_OFF_W-1:0];
                    r.span_length = (wm_off > rd_off) ? wm_off - rd_off : '0;
                end
            end
            bbsm_pkg::CMD_COMMIT_READ: rd_off = sat_to(rd_off, cnt, sz);
            bbsm_pkg::CMD_REQ_WRITE: begin
                if (rd_off <= wr_off) begin
                    tail   = (sz > wr_off) ? sz - wr_off : 0;
                    wm_off = wr_off;
                    if (tail >= cnt) begin
                        r.has_span    = 1'b1;
                        r.span_offset = wr_off[bbsm_pkg::SPAN_OFF_W-1:0];
                        r.span_length = bbsm_pkg::t_off'(tail);
                    end else if (rd_off > cnt) begin
                        // The tail is too short, so the head region is handed out.
                        wr_off        = '0;
                        r.has_span    = 1'b1;
                        r.span_length = rd_off - 1'b1;
                    end
                end else if (rd_off - wr_off > cnt) begin
                    r.has_span    = 1'b1;
                    r.span_offset = wr_off[bbsm_pkg::SPAN_OFF_W-1:0];
                    r.span_length = rd_off - wr_off - 1'b1;
                end
            end
            bbsm_pkg::CMD_COMMIT_WRITE: begin
                if (rd_off <= wr_off) begin
                    wr_off = sat_to(wr_off, cnt, sz);
                    wm_off = wr_off;
                end else begin
                    wr_off = sat_to(wr_off, cnt, sz);
                end
            end
            bbsm_pkg::CMD_RESET: begin
                rd_off = '0;
                wr_off = '0;
                wm_off = bbsm_pkg::t_off'(sz);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sends one command beat and queues the span that it should return.
    task automatic send_cmd(input logic [bbsm_pkg::CMD_W-1:0] cmd, input bbsm_pkg::t_off cnt,
                            output bbsm_pkg::t_result pred,
                            input logic is_typed = 1'b0,
                            input bbsm_pkg::t_result typed = '0);
        while (gaps_on && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_byte_count <= cnt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = span_predict(cmd, cnt);
        span_q.push_back(is_typed ? typed : pred);
    endtask

    // The size is only changed once every result has come back.
    task automatic write_size(input bbsm_pkg::t_off value);
        i_in_valid <= 1'b0;
        while (span_q.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_size = value;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(99) < 29);
    end

    always @(posedge i_clk) begin : chk_results
        bbsm_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (span_q.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, got %0d/%0d/%0d",
                         $realtime, o_has_span, o_span_offset, o_span_length);
                n_fail++;
            end else begin
                want = span_q.pop_front();
                if (o_has_span !== want.has_span) begin
                    $display("%0t: has_span expected %0d, got %0d",
                             $realtime, want.has_span, o_has_span);
                    n_fail++;
                end
                if (o_span_offset !== want.span_offset) begin
                    $display("%0t: span_offset expected %0d, got %0d",
                             $realtime, want.span_offset, o_span_offset);
                    n_fail++;
                end
                if (o_span_length !== want.span_length) begin
                    $display("%0t: span_length expected %0d, got %0d",
                             $realtime, want.span_length, o_span_length);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        bbsm_pkg::t_result          got;
        int unsigned                sz;
        int unsigned                n;
        bbsm_pkg::t_off             cnt;
        logic [bbsm_pkg::CMD_W-1:0] cmd;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_steps[k]) begin
            send_cmd(dir_steps[k].cmd, dir_steps[k].cnt, got, dir_steps[k].typed,
                     dir_steps[k].want);
        end

        for (int ph = 0; ph < N_PHASE; ph++) begin
            write_size(phase_sizes[ph]);
            gaps_on = (ph != QUIET_PHASE);
            sz      = eff_bytes(phase_sizes[ph]);
            n       = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(99) < 70) begin
                    // Well-formed use: a request followed by a commit within the span.
                    if ($urandom_range(1) == 1) begin
                        cnt = bbsm_pkg::t_off'($urandom_range(sz));
                        send_cmd(bbsm_pkg::CMD_REQ_WRITE, cnt, got);
                        if (got.has_span) begin
                            if (cnt <= got.span_length && $urandom_range(1) == 1)
                                send_cmd(bbsm_pkg::CMD_COMMIT_WRITE, cnt, got);
                            else
                                send_cmd(bbsm_pkg::CMD_COMMIT_WRITE,
                                         bbsm_pkg::t_off'($urandom_range(got.span_length)),
                                         got);
                            n++;
                        end
                    end else begin
                        send_cmd(bbsm_pkg::CMD_REQ_READ, bbsm_pkg::t_off'($urandom), got);
                        if (got.has_span) begin
                            send_cmd(bbsm_pkg::CMD_COMMIT_READ,
                                     bbsm_pkg::t_off'($urandom_range(got.span_length)), got);
                            n++;
                        end
                    end
                end else begin
                    cmd = bbsm_pkg::CMD_W'($urandom_range(7));
                    if ($urandom_range(1) == 1) cnt = bbsm_pkg::t_off'($urandom_range(sz + 1));
                    else                        cnt = bbsm_pkg::t_off'($urandom);
                    send_cmd(cmd, cnt, got);
                end
                n++;
            end
        end

        i_in_valid <= 1'b0;
        while (span_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
